FILE: rtl/core/pcof_pkg.sv
// Shared constants, register indexes and control types of the phase-current calibration filter.
package pcof_pkg;

  localparam int SAMPLE_W = 12;
  localparam int ADC_BITS = 12;
  localparam int CAL_SAMPLES_DEF = 64;

  localparam int OFS_W  = 12;
  localparam int GAIN_W = 20;
  localparam int KEEP_W = 16;
  localparam int CUR_W  = 20;
  localparam int FILT_W = 36;
  localparam int CFG_W  = 20;
  localparam int IDX_W  = 2;

  localparam int DIF_W = OFS_W + 1;
  localparam int P_W   = DIF_W + GAIN_W;
  localparam int E_W   = FILT_W + 1;
  localparam int EHI_W = E_W - KEEP_W;
  localparam int HI_W  = EHI_W + KEEP_W + 1;
  localparam int LO_W  = 2 * KEEP_W;
  localparam int ACC_W = FILT_W + 3;
  localparam int GAIN_FRAC = 12;
  localparam int SH_W  = FILT_W - GAIN_FRAC;

  localparam logic [OFS_W-1:0]         BIAS_IDEAL_RST = 12'd2048;
  localparam logic [OFS_W-1:0]         BIAS_ERR_RST   = 12'd200;
  localparam logic signed [GAIN_W-1:0] GAIN_RST       = 20'sd4096;
  localparam logic [KEEP_W-1:0]        KEEP_RST       = 16'd0;

  localparam logic signed [FILT_W-1:0] FILT_MAX = {1'b0, {(FILT_W-1){1'b1}}};
  localparam logic signed [FILT_W-1:0] FILT_MIN = {1'b1, {(FILT_W-1){1'b0}}};
  localparam logic signed [CUR_W-1:0]  CUR_MAX  = {1'b0, {(CUR_W-1){1'b1}}};
  localparam logic signed [CUR_W-1:0]  CUR_MIN  = {1'b1, {(CUR_W-1){1'b0}}};

  localparam logic [SAMPLE_W-1:0] ADC_MASK =
    SAMPLE_W'((64'(1) << ADC_BITS) - 64'(1));

  typedef enum logic [IDX_W-1:0] {
    REG_BIAS_IDEAL = 2'd0,
    REG_BIAS_ERR   = 2'd1,
    REG_GAIN       = 2'd2,
    REG_KEEP       = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic capture;
    logic cal_add;
    logic avg_load;
    logic cal_fix;
    logic mul_p;
    logic diff;
    logic mul_e;
    logic update;
    logic out_load;
  } pcof_cmd_t;

  typedef struct packed {
    logic cal_done;
    logic cal_last;
  } pcof_status_t;

endpackage

FILE: rtl/core/phase_current_offset_calibration_filter_core.sv
// Top level of the phase-current offset calibration and low-pass filter.
// Input channel: in_valid/in_stall with sample_a, sample_b, sample_c (one ADC set per item).
// Output channel: out_valid/out_stall with current_a..c, calibrated and offset_fault;
// exactly one result item per input item, in order.
// Configuration: cfg_write with cfg_index and cfg_data; write only while the block is idle.
// After reset the first CAL_SAMPLES items are summed per channel; their results carry
// zero currents with calibrated low. The last of them also forms the averages by a
// reciprocal multiply and runs the offset check before its result is loaded.
// Filtered items pass through gain multiply, difference, split filter multiply,
// accumulate and saturate, then the output register.
// The input stalls until the current item is loaded into the output register;
// the item sequencer handles one item at a time.
// The output register lets the next item be accepted while a result waits; when the
// receiver stalls, the finished item holds and the sequencer waits before loading the next.
// Reset clears the calibration sums, the filter state, the fault flag and all control
// state, and restores the configuration registers to their defaults.
module phase_current_offset_calibration_filter_core #(
  parameter int CAL_SAMPLES = pcof_pkg::CAL_SAMPLES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [pcof_pkg::IDX_W-1:0]         cfg_index,
  input  logic [pcof_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [pcof_pkg::SAMPLE_W-1:0]      sample_a,
  input  logic [pcof_pkg::SAMPLE_W-1:0]      sample_b,
  input  logic [pcof_pkg::SAMPLE_W-1:0]      sample_c,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [pcof_pkg::CUR_W-1:0]  current_a,
  output logic signed [pcof_pkg::CUR_W-1:0]  current_b,
  output logic signed [pcof_pkg::CUR_W-1:0]  current_c,
  output logic                               calibrated,
  output logic                               offset_fault
);

  pcof_pkg::pcof_cmd_t                  cmd;
  pcof_pkg::pcof_status_t               status;
  logic signed [pcof_pkg::CUR_W-1:0]    cur_out [3];

  pcof_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  pcof_dp #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample_a  (sample_a),
    .sample_b  (sample_b),
    .sample_c  (sample_c),
    .cmd       (cmd),
    .status    (status),
    .cur_out   (cur_out),
    .cal_out   (calibrated),
    .fault_out (offset_fault)
  );

  assign current_a = cur_out[0];
  assign current_b = cur_out[1];
  assign current_c = cur_out[2];

endmodule

FILE: rtl/core/pcof_dp.sv
// Datapath: configuration registers, offset calibration, reciprocal averaging and low-pass filter.
module pcof_dp #(
  parameter int CAL_SAMPLES = pcof_pkg::CAL_SAMPLES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [pcof_pkg::IDX_W-1:0]            cfg_index,
  input  logic [pcof_pkg::CFG_W-1:0]            cfg_data,
  input  logic [pcof_pkg::SAMPLE_W-1:0]         sample_a,
  input  logic [pcof_pkg::SAMPLE_W-1:0]         sample_b,
  input  logic [pcof_pkg::SAMPLE_W-1:0]         sample_c,
  input  pcof_pkg::pcof_cmd_t                   cmd,
  output pcof_pkg::pcof_status_t                status,
  output logic signed [pcof_pkg::CUR_W-1:0]     cur_out [3],
  output logic                                  cal_out,
  output logic                                  fault_out
);

  localparam int CNT_W = $clog2(CAL_SAMPLES);
  localparam int SUM_W = pcof_pkg::SAMPLE_W + CNT_W;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAL_SAMPLES - 1);
  localparam int AVG_SH = SUM_W + CNT_W;
  localparam int RCP_W  = SUM_W + 1;
  localparam int AVG_PW = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] AVG_RCP =
    RCP_W'(((64'd1 << AVG_SH) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

  logic [pcof_pkg::OFS_W-1:0]          bias_ideal;
  logic [pcof_pkg::OFS_W-1:0]          bias_err;
  logic signed [pcof_pkg::GAIN_W-1:0]  gain;
  logic [pcof_pkg::KEEP_W-1:0]         keep;

  logic [pcof_pkg::SAMPLE_W-1:0]       smp [3];
  logic                                item_valid;
  logic [SUM_W-1:0]                    sums [3];
  logic [CNT_W-1:0]                    count;
  logic [AVG_PW-1:0]                   avg_prod [3];
  logic [pcof_pkg::OFS_W-1:0]          quo [3];
  logic [pcof_pkg::OFS_W-1:0]          offsets [3];
  logic                                cal_done;
  logic                                fault;
  logic signed [pcof_pkg::P_W-1:0]     p [3];
  logic signed [pcof_pkg::E_W-1:0]     e [3];
  logic signed [pcof_pkg::HI_W-1:0]    prod_hi [3];
  logic [pcof_pkg::LO_W-1:0]           prod_lo [3];
  logic signed [pcof_pkg::FILT_W-1:0]  filt [3];

  logic signed [pcof_pkg::DIF_W-1:0]   dif [3];
  logic signed [pcof_pkg::ACC_W-1:0]   acc [3];
  logic signed [pcof_pkg::FILT_W-1:0]  filt_next [3];
  logic signed [pcof_pkg::SH_W-1:0]    sh [3];
  logic signed [pcof_pkg::CUR_W-1:0]   cur_next [3];
  logic [pcof_pkg::OFS_W-1:0]          dev [3];
  logic                                bad;
  logic signed [pcof_pkg::EHI_W-1:0]   e_hi [3];
  logic signed [pcof_pkg::KEEP_W:0]    keep_s;

  assign status.cal_done = cal_done;
  assign status.cal_last = (count == CNT_LAST);
  assign keep_s = $signed({1'b0, keep});

  always_comb begin
    bad = 1'b0;
    for (int i = 0; i < 3; i++) begin
      avg_prod[i] = AVG_PW'(sums[i]) * AVG_PW'(AVG_RCP);
      dif[i] = $signed({1'b0, offsets[i]}) - $signed({1'b0, smp[i]});
      e_hi[i] = $signed(e[i][pcof_pkg::E_W-1:pcof_pkg::KEEP_W]);
      acc[i] = pcof_pkg::ACC_W'(p[i]) + pcof_pkg::ACC_W'(prod_hi[i])
             + pcof_pkg::ACC_W'($signed({1'b0, prod_lo[i][pcof_pkg::LO_W-1:pcof_pkg::KEEP_W]}));
      if (acc[i] > pcof_pkg::ACC_W'(pcof_pkg::FILT_MAX)) begin
        filt_next[i] = pcof_pkg::FILT_MAX;
      end else if (acc[i] < pcof_pkg::ACC_W'(pcof_pkg::FILT_MIN)) begin
        filt_next[i] = pcof_pkg::FILT_MIN;
      end else begin
        filt_next[i] = acc[i][pcof_pkg::FILT_W-1:0];
      end
      sh[i] = $signed(filt[i][pcof_pkg::FILT_W-1:pcof_pkg::GAIN_FRAC]);
      if (sh[i] > pcof_pkg::SH_W'(pcof_pkg::CUR_MAX)) begin
        cur_next[i] = pcof_pkg::CUR_MAX;
      end else if (sh[i] < pcof_pkg::SH_W'(pcof_pkg::CUR_MIN)) begin
        cur_next[i] = pcof_pkg::CUR_MIN;
      end else begin
        cur_next[i] = sh[i][pcof_pkg::CUR_W-1:0];
      end
      dev[i] = (quo[i] > bias_ideal) ? quo[i] - bias_ideal : bias_ideal - quo[i];
      if (dev[i] > bias_err) begin
        bad = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bias_ideal <= pcof_pkg::BIAS_IDEAL_RST;
      bias_err   <= pcof_pkg::BIAS_ERR_RST;
      gain       <= pcof_pkg::GAIN_RST;
      keep       <= pcof_pkg::KEEP_RST;
    end else if (cfg_write) begin
      case (pcof_pkg::reg_idx_t'(cfg_index))
        pcof_pkg::REG_BIAS_IDEAL: bias_ideal <= cfg_data[pcof_pkg::OFS_W-1:0];
        pcof_pkg::REG_BIAS_ERR:   bias_err   <= cfg_data[pcof_pkg::OFS_W-1:0];
        pcof_pkg::REG_GAIN:       gain       <= $signed(cfg_data[pcof_pkg::GAIN_W-1:0]);
        pcof_pkg::REG_KEEP:       keep       <= cfg_data[pcof_pkg::KEEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      cal_done <= 1'b0;
      fault    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sums[i] <= '0;
        filt[i] <= '0;
      end
    end else begin
      if (cmd.cal_add) begin
        if (!status.cal_last) begin
          count <= count + CNT_W'(1);
        end
        for (int i = 0; i < 3; i++) begin
          sums[i] <= sums[i] + SUM_W'(smp[i]);
        end
      end
      if (cmd.cal_fix) begin
        cal_done <= 1'b1;
        fault    <= fault | bad;
      end
      if (cmd.update) begin
        for (int i = 0; i < 3; i++) begin
          filt[i] <= filt_next[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      smp[0]     <= sample_a & pcof_pkg::ADC_MASK;
      smp[1]     <= sample_b & pcof_pkg::ADC_MASK;
      smp[2]     <= sample_c & pcof_pkg::ADC_MASK;
      item_valid <= cal_done;
    end
    for (int i = 0; i < 3; i++) begin
      if (cmd.avg_load) begin
        quo[i] <= avg_prod[i][AVG_SH +: pcof_pkg::OFS_W];
      end
      if (cmd.cal_fix) begin
        offsets[i] <= bad ? bias_ideal : quo[i];
      end
      if (cmd.mul_p) begin
        p[i] <= pcof_pkg::P_W'(dif[i]) * pcof_pkg::P_W'(gain);
      end
      if (cmd.diff) begin
        e[i] <= pcof_pkg::E_W'(filt[i]) - pcof_pkg::E_W'(p[i]);
      end
      if (cmd.mul_e) begin
        prod_hi[i] <= pcof_pkg::HI_W'(e_hi[i]) * pcof_pkg::HI_W'(keep_s);
        prod_lo[i] <= e[i][pcof_pkg::KEEP_W-1:0] * keep;
      end
      if (cmd.out_load) begin
        cur_out[i] <= item_valid ? cur_next[i] : '0;
      end
    end
    if (cmd.out_load) begin
      cal_out   <= item_valid;
      fault_out <= fault;
    end
  end

endmodule

FILE: rtl/core/pcof_ctrl.sv
// Controller: sequences calibration, averaging, filtering and the output register.
module pcof_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  pcof_pkg::pcof_status_t status,
  output pcof_pkg::pcof_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CAL_ADD,
    S_AVG,
    S_CHECK,
    S_MUL_P,
    S_DIFF,
    S_MUL_E,
    S_UPDATE,
    S_WRITE
  } state_t;

  state_t                        state;
  logic                          accept;
  logic                          out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd          = '0;
    cmd.capture  = accept;
    cmd.cal_add  = (state == S_CAL_ADD);
    cmd.avg_load = (state == S_AVG);
    cmd.cal_fix  = (state == S_CHECK);
    cmd.mul_p    = (state == S_MUL_P);
    cmd.diff     = (state == S_DIFF);
    cmd.mul_e    = (state == S_MUL_E);
    cmd.update   = (state == S_UPDATE);
    cmd.out_load = (state == S_WRITE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= status.cal_done ? S_MUL_P : S_CAL_ADD;
          end
        end
        S_CAL_ADD: state <= status.cal_last ? S_AVG : S_WRITE;
        S_AVG:     state <= S_CHECK;
        S_CHECK:   state <= S_WRITE;
        S_MUL_P:   state <= S_DIFF;
        S_DIFF:    state <= S_MUL_E;
        S_MUL_E:   state <= S_UPDATE;
        S_UPDATE:  state <= S_WRITE;
        S_WRITE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: tb/current_filter_checker.sv
`timescale 1ns / 100ps
// Checker that predicts and compares the filtered phase currents of the calibration filter.
module current_filter_checker
  import pcof_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [SAMPLE_W-1:0]     sample_a,
  input  logic [SAMPLE_W-1:0]     sample_b,
  input  logic [SAMPLE_W-1:0]     sample_c,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [CUR_W-1:0] current_a,
  input  logic signed [CUR_W-1:0] current_b,
  input  logic signed [CUR_W-1:0] current_c,
  input  logic                    calibrated,
  input  logic                    offset_fault,
  output int                      mismatches,
  output int                      outstanding
);

  localparam int CAL_COUNT = CAL_SAMPLES_DEF;
  localparam int SUM_W = SAMPLE_W + $clog2(CAL_COUNT);
  localparam longint KEEP_ONE = longint'(1) << KEEP_W;
  localparam longint FMAX = longint'(FILT_MAX);
  localparam longint FMIN = longint'(FILT_MIN);
  localparam longint CMAX = longint'(CUR_MAX);
  localparam longint CMIN = longint'(CUR_MIN);

  typedef struct packed {
    logic signed [CUR_W-1:0] cur_a;
    logic signed [CUR_W-1:0] cur_b;
    logic signed [CUR_W-1:0] cur_c;
    logic                    cal;
    logic                    fault;
  } phase_result_t;

  logic [OFS_W-1:0]         bias_ideal_q;
  logic [OFS_W-1:0]         bias_err_q;
  logic signed [GAIN_W-1:0] gain_q;
  logic [KEEP_W-1:0]        keep_q;

  logic [SUM_W-1:0]         cal_sum [3];
  int                       cal_count;
  logic [OFS_W-1:0]         zero_ofs [3];
  logic signed [FILT_W-1:0] filt [3];
  logic                     cal_done;
  logic                     fault_flag;

  phase_result_t expected_currents [$];

  function automatic phase_result_t predict_currents(input logic [SAMPLE_W-1:0] a,
                                                     input logic [SAMPLE_W-1:0] b,
                                                     input logic [SAMPLE_W-1:0] c);
    logic [SAMPLE_W-1:0]     s [3];
    logic [OFS_W-1:0]        avg;
    logic [OFS_W-1:0]        dev;
    logic                    bad;
    logic                    valid;
    longint                  p;
    longint                  acc;
    longint                  f;
    longint                  q;
    logic signed [CUR_W-1:0] cur [3];
    phase_result_t           r;
    s[0] = a & ADC_MASK;
    s[1] = b & ADC_MASK;
    s[2] = c & ADC_MASK;
    bad = 1'b0;
    valid = 1'b0;
    for (int i = 0; i < 3; i++) cur[i] = '0;
    if (!cal_done) begin
      for (int i = 0; i < 3; i++) cal_sum[i] = cal_sum[i] + s[i];
      cal_count++;
      if (cal_count >= CAL_COUNT) begin
        for (int i = 0; i < 3; i++) begin
          avg = OFS_W'(cal_sum[i] / CAL_COUNT);
          dev = (avg > bias_ideal_q) ? avg - bias_ideal_q : bias_ideal_q - avg;
          zero_ofs[i] = avg;
          if (dev > bias_err_q) bad = 1'b1;
        end
        if (bad) begin
          for (int i = 0; i < 3; i++) zero_ofs[i] = bias_ideal_q;
          fault_flag = 1'b1;
        end
        cal_done = 1'b1;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        p = (longint'(zero_ofs[i]) - longint'(s[i])) * longint'(gain_q);
        acc = longint'(filt[i]) * longint'(keep_q) + p * (KEEP_ONE - longint'(keep_q));
        f = acc >>> KEEP_W;
        if (f > FMAX) f = FMAX;
        else if (f < FMIN) f = FMIN;
        filt[i] = FILT_W'(f);
        q = f >>> GAIN_FRAC;
        if (q > CMAX) q = CMAX;
        else if (q < CMIN) q = CMIN;
        cur[i] = CUR_W'(q);
      end
      valid = 1'b1;
    end
    r.cur_a = cur[0];
    r.cur_b = cur[1];
    r.cur_c = cur[2];
    r.cal = valid;
    r.fault = fault_flag;
    return r;
  endfunction

  always @(posedge clk) begin
    phase_result_t want;
    phase_result_t got;
    if (rst) begin
      bias_ideal_q = BIAS_IDEAL_RST;
      bias_err_q = BIAS_ERR_RST;
      gain_q = GAIN_RST;
      keep_q = KEEP_RST;
      for (int i = 0; i < 3; i++) begin
        cal_sum[i] = '0;
        zero_ofs[i] = '0;
        filt[i] = '0;
      end
      cal_count = 0;
      cal_done = 1'b0;
      fault_flag = 1'b0;
      expected_currents.delete();
      outstanding <= 0;
    end else begin
      if (cfg_write) begin
        case (reg_idx_t'(cfg_index))
          REG_BIAS_IDEAL: bias_ideal_q = cfg_data[OFS_W-1:0];
          REG_BIAS_ERR:   bias_err_q = cfg_data[OFS_W-1:0];
          REG_GAIN:       gain_q = cfg_data[GAIN_W-1:0];
          REG_KEEP:       keep_q = cfg_data[KEEP_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_currents.push_back(predict_currents(sample_a, sample_b, sample_c));
      if (out_valid && !out_stall) begin
        got.cur_a = current_a;
        got.cur_b = current_b;
        got.cur_c = current_c;
        got.cal = calibrated;
        got.fault = offset_fault;
        if (expected_currents.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item: %0d %0d %0d cal %0b fault %0b",
                     got.cur_a, got.cur_b, got.cur_c, got.cal, got.fault);
        end else begin
          want = expected_currents.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %0d %0d %0d cal %0b fault %0b, got %0d %0d %0d cal %0b fault %0b",
                       want.cur_a, want.cur_b, want.cur_c, want.cal, want.fault,
                       got.cur_a, got.cur_b, got.cur_c, got.cal, got.fault);
          end
        end
      end
      outstanding <= expected_currents.size();
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Top of the testbench: drives samples, settings and output stalls, and gives the verdict.
module testbench;
  import pcof_pkg::*;

  localparam int CAL_COUNT = CAL_SAMPLES_DEF;
  localparam int RANDOM_ITEMS = 1500;
  localparam int CODE_MAX = (1 << SAMPLE_W) - 1;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    cfg_write = 1'b0;
  logic [IDX_W-1:0]        cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [SAMPLE_W-1:0]     sample_a = '0;
  logic [SAMPLE_W-1:0]     sample_b = '0;
  logic [SAMPLE_W-1:0]     sample_c = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [CUR_W-1:0] current_a;
  logic signed [CUR_W-1:0] current_b;
  logic signed [CUR_W-1:0] current_c;
  logic                    calibrated;
  logic                    offset_fault;

  int mismatches;
  int outstanding;
  int items_sent = 0;
  int send_idle_pct = 10;
  int recv_idle_pct = 55;
  int zero_code [3];

  phase_current_offset_calibration_filter_core uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample_a(sample_a), .sample_b(sample_b), .sample_c(sample_c),
    .out_valid(out_valid), .out_stall(out_stall),
    .current_a(current_a), .current_b(current_b), .current_c(current_c),
    .calibrated(calibrated), .offset_fault(offset_fault)
  );

  current_filter_checker watch (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample_a(sample_a), .sample_b(sample_b), .sample_c(sample_c),
    .out_valid(out_valid), .out_stall(out_stall),
    .current_a(current_a), .current_b(current_b), .current_c(current_c),
    .calibrated(calibrated), .offset_fault(offset_fault),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  task automatic send_item(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b,
                           input logic [SAMPLE_W-1:0] c);
    in_valid <= 1'b1;
    sample_a <= a;
    sample_b <= b;
    sample_c <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (items_sent == 525) begin
      send_idle_pct = 55;
      recv_idle_pct = 10;
    end else if (items_sent == 1050) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_settings(input logic [OFS_W-1:0] ideal, input logic [OFS_W-1:0] err_max,
                                input logic signed [GAIN_W-1:0] gain,
                                input logic [KEEP_W-1:0] keep);
    logic [CFG_W-1:0] word [4];
    reg_idx_t         order [4];
    order[0] = REG_BIAS_IDEAL;
    order[1] = REG_BIAS_ERR;
    order[2] = REG_GAIN;
    order[3] = REG_KEEP;
    // unused upper bits carry noise
    word[0] = CFG_W'($urandom);
    word[0][OFS_W-1:0] = ideal;
    word[1] = CFG_W'($urandom);
    word[1][OFS_W-1:0] = err_max;
    word[2] = CFG_W'($urandom);
    word[2][GAIN_W-1:0] = gain;
    word[3] = CFG_W'($urandom);
    word[3][KEEP_W-1:0] = keep;
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= order[i];
      cfg_data <= word[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic send_extremes();
    send_item('0, '0, '0);
    send_item('1, '1, '1);
    send_item('0, '1, SAMPLE_W'(zero_code[2]));
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input int ch);
    int pick;
    int v;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      v = zero_code[ch] + int'($urandom_range(0, 126)) - 63;
      if (v < 0) v = 0;
      if (v > CODE_MAX) v = CODE_MAX;
    end else if (pick < 8) begin
      v = $urandom_range(0, CODE_MAX);
    end else begin
      v = $urandom_range(0, 1) ? CODE_MAX : 0;
    end
    return SAMPLE_W'(v);
  endfunction

  initial begin
    int ideal_code;
    int err_code;
    int fault_mode;
    int lopsided;
    int dev;
    int avg;
    int span;
    int rem;
    int d;
    int sent;
    int burst;
    int drain;
    logic signed [GAIN_W-1:0] gain;
    logic [KEEP_W-1:0]        keep;
    logic [OFS_W-1:0]         ideal;
    logic [OFS_W-1:0]         err_max;
    logic [SAMPLE_W-1:0]      cal_smp [3][CAL_COUNT];

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // calibrate either at the reset settings or at fresh ones
    if ($urandom_range(0, 1)) begin
      ideal_code = $urandom_range(300, 3795);
      err_code = $urandom_range(0, 250);
      write_settings(OFS_W'(ideal_code), OFS_W'(err_code), GAIN_W'($urandom), KEEP_W'($urandom));
    end else begin
      ideal_code = BIAS_IDEAL_RST;
      err_code = BIAS_ERR_RST;
    end

    // one channel sits on the tolerance edge, or just past it
    fault_mode = ($urandom_range(0, 3) == 0) ? 1 : 0;
    lopsided = $urandom_range(0, 2);
    for (int ch = 0; ch < 3; ch++) begin
      dev = (ch == lopsided) ? err_code + fault_mode : $urandom_range(0, err_code);
      avg = $urandom_range(0, 1) ? ideal_code + dev : ideal_code - dev;
      span = (avg < CODE_MAX - avg) ? avg : CODE_MAX - avg;
      rem = $urandom_range(0, (CODE_MAX - avg < 63) ? CODE_MAX - avg : 63);
      for (int k = 0; k < CAL_COUNT / 2; k++) begin
        d = (k == 0) ? span : $urandom_range(0, span);
        cal_smp[ch][2*k] = SAMPLE_W'(avg + d);
        cal_smp[ch][2*k+1] = SAMPLE_W'(avg - d);
      end
      cal_smp[ch][1] = cal_smp[ch][1] + SAMPLE_W'(rem);
      zero_code[ch] = fault_mode ? ideal_code : avg;
    end
    for (int k = 0; k < CAL_COUNT; k++)
      send_item(cal_smp[0][k], cal_smp[1][k], cal_smp[2][k]);

    wait_idle();
    write_settings(OFS_W'($urandom), OFS_W'($urandom), {1'b0, {(GAIN_W-1){1'b1}}}, '0);
    send_extremes();
    wait_idle();
    write_settings('1, '0, {1'b1, {(GAIN_W-1){1'b0}}}, '0);
    send_extremes();
    wait_idle();
    write_settings('0, '1, GAIN_RST, '1);
    send_extremes();
    send_item('1, '0, '1);
    wait_idle();
    write_settings(OFS_W'($urandom), OFS_W'($urandom), '0, KEEP_W'(1));
    send_item('1, '0, '1);
    send_item('0, '1, '0);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      case ($urandom_range(0, 4))
        0: gain = {1'b1, {(GAIN_W-1){1'b0}}};
        1: gain = {1'b0, {(GAIN_W-1){1'b1}}};
        2: gain = '0;
        3: gain = GAIN_RST;
        default: gain = GAIN_W'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0: keep = '0;
        1: keep = '1;
        2: keep = KEEP_W'(1);
        default: keep = KEEP_W'($urandom);
      endcase
      case ($urandom_range(0, 2))
        0: ideal = '0;
        1: ideal = '1;
        default: ideal = OFS_W'($urandom);
      endcase
      case ($urandom_range(0, 2))
        0: err_max = '0;
        1: err_max = '1;
        default: err_max = OFS_W'($urandom);
      endcase
      write_settings(ideal, err_max, gain, keep);
      burst = $urandom_range(10, 100);
      repeat (burst) begin
        send_item(pick_sample(0), pick_sample(1), pick_sample(2));
        sent++;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    drain = 0;
    while (outstanding != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
